>>> rtl/bdel_pkg.sv
package bdel_pkg;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned HOLD_W     = 6;
    localparam int unsigned PRE_W      = 8;
    localparam int unsigned SLOTCFG_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [HOLD_W-1:0]    DEBOUNCE_RST = 6'd20;
    localparam logic [PRE_W-1:0]     PRESCALE_RST = 8'd10;
    localparam logic [SLOTCFG_W-1:0] FIRST_RST    = 4'd0;
    localparam logic [SLOTCFG_W-1:0] SECOND_RST   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_PRESCALE = 2'd1,
        CFG_FIRST    = 2'd2,
        CFG_SECOND   = 2'd3
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Operation applied to one slot by a read/write pair on the slot store.
    typedef enum logic [2:0] {
        OP_BTN1  = 3'd0,
        OP_BTN2  = 3'd1,
        OP_READ  = 3'd2,
        OP_RESET = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef struct packed {
        logic              level;
        logic              latch;
        logic [HOLD_W-1:0] hold;
    } slot_t;

    typedef struct packed {
        op_t  op;
        logic capture;
        logic tick_step;
        logic rd;
        logic wr;
        logic cnt_clr;
        logic cnt_inc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
    } sts_t;

endpackage

>>> rtl/bdel_datapath.sv
module bdel_datapath #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bdel_pkg::cmd_t                     cmd_i,
    output bdel_pkg::sts_t                     sts_o,
    input  logic                               s_raw_one,
    input  logic                               s_raw_two,
    input  logic [bdel_pkg::IDX_W-1:0]         s_slot_index,
    output logic                               m_press_seen,
    input  logic                               cfg_we,
    input  logic [bdel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdel_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

    logic [bdel_pkg::HOLD_W-1:0]    debounce_reg;
    logic [bdel_pkg::PRE_W-1:0]     prescale_reload_reg;
    logic [bdel_pkg::SLOTCFG_W-1:0] first_slot_reg;
    logic [bdel_pkg::SLOTCFG_W-1:0] second_slot_reg;
    logic [bdel_pkg::PRE_W-1:0]     prescale_reg;
    logic [SLOT_W-1:0]              cnt_reg;
    logic                           raw_one_reg;
    logic                           raw_two_reg;
    logic [bdel_pkg::IDX_W-1:0]     idx_reg;
    logic                           seen_reg;
    logic                           m_press_seen_reg;
    bdel_pkg::slot_t                rdata_reg;
    bdel_pkg::slot_t                mem [NUM_SLOTS];

    logic [bdel_pkg::IDX_W-1:0]     addr_full;
    logic                           in_range;
    logic [SLOT_W-1:0]              addr;
    bdel_pkg::slot_t                wdata;
    logic                           raw;
    logic [bdel_pkg::HOLD_W-1:0]    hold_mid;

    always_comb begin
        case (cmd_i.op)
            bdel_pkg::OP_BTN1: addr_full = bdel_pkg::IDX_W'(first_slot_reg);
            bdel_pkg::OP_BTN2: addr_full = bdel_pkg::IDX_W'(second_slot_reg);
            bdel_pkg::OP_READ: addr_full = idx_reg;
            default:           addr_full = bdel_pkg::IDX_W'(cnt_reg);
        endcase
    end

    assign in_range = (addr_full < bdel_pkg::IDX_W'(NUM_SLOTS));
    assign addr     = addr_full[SLOT_W-1:0];
    assign raw      = (cmd_i.op == bdel_pkg::OP_BTN1) ? raw_one_reg : raw_two_reg;

    // Button update: a level change outside the hold-off is a press or a release;
    // the hold-off then counts down on prescaler wrap.
    always_comb begin
        wdata    = rdata_reg;
        hold_mid = rdata_reg.hold;
        case (cmd_i.op)
            bdel_pkg::OP_BTN1, bdel_pkg::OP_BTN2: begin
                wdata.level = raw;
                if (raw != rdata_reg.level && rdata_reg.hold == '0) begin
                    if (!raw) begin
                        hold_mid = debounce_reg;
                    end else begin
                        wdata.latch = 1'b1;
                    end
                end
                if (prescale_reg == '0 && hold_mid != '0) begin
                    wdata.hold = hold_mid - 1'b1;
                end else begin
                    wdata.hold = hold_mid;
                end
            end
            bdel_pkg::OP_READ, bdel_pkg::OP_CLEAR: begin
                wdata.latch = 1'b0;
            end
            bdel_pkg::OP_RESET: begin
                wdata = '{level: 1'b0, latch: 1'b0, hold: debounce_reg};
            end
            default: begin
                wdata = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.rd && in_range) begin
            rdata_reg <= mem[addr];
        end
        if (cmd_i.wr && in_range) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg        <= bdel_pkg::DEBOUNCE_RST;
            prescale_reload_reg <= bdel_pkg::PRESCALE_RST;
            first_slot_reg      <= bdel_pkg::FIRST_RST;
            second_slot_reg     <= bdel_pkg::SECOND_RST;
            prescale_reg        <= '0;
            cnt_reg             <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bdel_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata[bdel_pkg::HOLD_W-1:0];
                    bdel_pkg::CFG_PRESCALE: prescale_reload_reg <= cfg_wdata;
                    bdel_pkg::CFG_FIRST:    first_slot_reg <= cfg_wdata[bdel_pkg::SLOTCFG_W-1:0];
                    bdel_pkg::CFG_SECOND:   second_slot_reg <= cfg_wdata[bdel_pkg::SLOTCFG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_i.tick_step) begin
                if (prescale_reg == '0) begin
                    prescale_reg <= prescale_reload_reg;
                end else begin
                    prescale_reg <= prescale_reg - 1'b1;
                end
            end
            if (cmd_i.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd_i.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            raw_one_reg <= s_raw_one;
            raw_two_reg <= s_raw_two;
            idx_reg     <= s_slot_index;
            seen_reg    <= 1'b0;
        end else if (cmd_i.wr && in_range && cmd_i.op == bdel_pkg::OP_READ) begin
            seen_reg <= rdata_reg.latch;
        end
        if (cmd_i.out_load) begin
            m_press_seen_reg <= seen_reg;
        end
    end

    assign sts_o.cnt_last = (cnt_reg == SLOT_W'(NUM_SLOTS - 1));
    assign m_press_seen   = m_press_seen_reg;

endmodule

>>> rtl/bdel_ctrl.sv
module bdel_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdel_pkg::KIND_W-1:0]   s_kind,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bdel_pkg::cmd_t                cmd_o,
    input  bdel_pkg::sts_t                sts_i
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_FIN
    } state_t;

    state_t          state_reg, state_next;
    bdel_pkg::op_t   op_reg, op_next;
    logic            init_reg, init_next;
    logic            m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        init_next    = init_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd_o        = '0;
        cmd_o.op     = op_reg;
        s_ready      = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_o.capture = 1'b1;
                    state_next    = S_RD;
                    case (s_kind)
                        bdel_pkg::KIND_TICK: op_next = bdel_pkg::OP_BTN1;
                        bdel_pkg::KIND_READ: op_next = bdel_pkg::OP_READ;
                        bdel_pkg::KIND_RESET: begin
                            op_next       = bdel_pkg::OP_RESET;
                            cmd_o.cnt_clr = 1'b1;
                        end
                        default: begin
                            op_next       = bdel_pkg::OP_CLEAR;
                            cmd_o.cnt_clr = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                cmd_o.rd        = 1'b1;
                cmd_o.tick_step = (op_reg == bdel_pkg::OP_BTN1);
                state_next      = S_WR;
            end
            S_WR: begin
                cmd_o.wr = 1'b1;
                if (op_reg == bdel_pkg::OP_BTN1) begin
                    op_next    = bdel_pkg::OP_BTN2;
                    state_next = S_RD;
                end else if (op_reg inside {bdel_pkg::OP_RESET, bdel_pkg::OP_CLEAR}) begin
                    cmd_o.cnt_inc = 1'b1;
                    if (!sts_i.cnt_last) begin
                        state_next = S_RD;
                    end else if (init_reg) begin
                        // The power-up clearing pass has no request behind it.
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd_o.out_load = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RD;
            op_reg      <= bdel_pkg::OP_RESET;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in progress");
    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.wr |-> $past(cmd_o.rd))
        else $error("slot write without preceding read");
    a_no_req_during_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !s_ready)
        else $error("request accepted during clearing pass");
`endif

endmodule

>>> rtl/button_debounce_edge_latch.sv
// Button debounce with press latch for NUM_SLOTS slots.
// Requests arrive on the s_ channel (valid/ready) with s_kind: a tick carrying
// the raw levels of two buttons, a read-and-clear of one slot's press latch,
// a reset of all slots, or a clear of all latches. Every request gives exactly
// one result on the m_ channel; m_press_seen is the latch value for a read and
// 0 otherwise. Configuration is written through cfg_we/cfg_index/cfg_wdata
// while the block is idle: a rule for the user, not enforced by the block.
// Slot state lives in a single-port store, one read or one write per cycle,
// and each slot touched costs a read and a write. Only one request is in
// progress at a time. After reset the block sweeps the store, resetting
// every slot, and s_ready stays low until the sweep ends. A finished result
// waits in the output register while the receiver stalls; the next request
// may be accepted meanwhile, and it holds in its last step until the output
// register is free.
module button_debounce_edge_latch #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bdel_pkg::KIND_W-1:0]        s_kind,
    input  logic                               s_raw_one,
    input  logic                               s_raw_two,
    input  logic [bdel_pkg::IDX_W-1:0]         s_slot_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_press_seen,
    input  logic                               cfg_we,
    input  logic [bdel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdel_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    bdel_pkg::cmd_t cmd;
    bdel_pkg::sts_t sts;

    bdel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    bdel_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (cmd),
        .sts_o        (sts),
        .s_raw_one    (s_raw_one),
        .s_raw_two    (s_raw_two),
        .s_slot_index (s_slot_index),
        .m_press_seen (m_press_seen),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

endmodule

>>> dv/button_debounce_edge_latch_tb.sv
`timescale 1ns / 100ps

module button_debounce_edge_latch_tb;

    localparam int NUM_SLOTS       = 16;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int STALL_LIMIT     = 3000;
    localparam int TAIL_CYCLES     = 2 * NUM_SLOTS + 8;
    localparam int MAX_REPORTS     = 10;

    // Predicts the press_seen value of every accepted request.
    class debounce_scoreboard;
        bit                                 level [NUM_SLOTS];
        bit                                 latch [NUM_SLOTS];
        logic [bdel_pkg::HOLD_W-1:0]        hold [NUM_SLOTS];
        logic [bdel_pkg::PRE_W-1:0]         prescale;
        logic [bdel_pkg::HOLD_W-1:0]        debounce_time;
        logic [bdel_pkg::PRE_W-1:0]         prescale_reload;
        logic [bdel_pkg::SLOTCFG_W-1:0]     first_slot;
        logic [bdel_pkg::SLOTCFG_W-1:0]     second_slot;
        bit                                 seen_q [$];
        int                                 failures;

        function new();
            debounce_time   = bdel_pkg::DEBOUNCE_RST;
            prescale_reload = bdel_pkg::PRESCALE_RST;
            first_slot      = bdel_pkg::FIRST_RST;
            second_slot     = bdel_pkg::SECOND_RST;
            prescale        = '0;
            failures        = 0;
            reset_slots(bdel_pkg::DEBOUNCE_RST);
        endfunction

        function void reset_slots(logic [bdel_pkg::HOLD_W-1:0] load);
            foreach (level[i]) begin
                level[i] = 1'b0;
                latch[i] = 1'b0;
                hold[i]  = load;
            end
        endfunction

        function void set_reg(bdel_pkg::cfg_idx_t idx,
                              logic [bdel_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bdel_pkg::CFG_DEBOUNCE: debounce_time   = data[bdel_pkg::HOLD_W-1:0];
                bdel_pkg::CFG_PRESCALE: prescale_reload = data[bdel_pkg::PRE_W-1:0];
                bdel_pkg::CFG_FIRST:    first_slot      = data[bdel_pkg::SLOTCFG_W-1:0];
                bdel_pkg::CFG_SECOND:   second_slot     = data[bdel_pkg::SLOTCFG_W-1:0];
                default: ;
            endcase
        endfunction

        function void press_step(int slot, bit lvl);
            if (slot >= NUM_SLOTS)
                return;
            if (lvl != level[slot]) begin
                level[slot] = lvl;
                if (hold[slot] == 0) begin
                    if (!lvl)
                        hold[slot] = debounce_time;
                    else
                        latch[slot] = 1'b1;
                end
            end
            // The hold-off count only moves on ticks where the prescaler has just hit zero.
            if (prescale == 0 && hold[slot] != 0)
                hold[slot] = hold[slot] - 1'b1;
        endfunction

        function void note_request(bdel_pkg::kind_t kind, bit one, bit two,
                                   logic [bdel_pkg::IDX_W-1:0] idx);
            bit seen;
            seen = 1'b0;
            case (kind)
                bdel_pkg::KIND_TICK: begin
                    if (prescale != 0)
                        prescale = prescale - 1'b1;
                    else
                        prescale = prescale_reload;
                    press_step(int'(first_slot), one);
                    press_step(int'(second_slot), two);
                end
                bdel_pkg::KIND_READ: begin
                    if (idx < NUM_SLOTS) begin
                        seen       = latch[idx];
                        latch[idx] = 1'b0;
                    end
                end
                bdel_pkg::KIND_RESET: reset_slots(debounce_time);
                default: begin
                    foreach (latch[i])
                        latch[i] = 1'b0;
                end
            endcase
            seen_q.push_back(seen);
        endfunction

        function void check_result(bit actual);
            bit wanted;
            if (seen_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] result with no request outstanding: press_seen=%0b",
                             $realtime, actual);
                return;
            end
            wanted = seen_q.pop_front();
            if (wanted != actual) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] press_seen mismatch: expected %0b, got %0b",
                             $realtime, wanted, actual);
            end
        endfunction

        function int pending();
            return seen_q.size();
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [bdel_pkg::KIND_W-1:0]       s_kind;
    logic                              s_raw_one;
    logic                              s_raw_two;
    logic [bdel_pkg::IDX_W-1:0]        s_slot_index;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_press_seen;
    logic                              cfg_we;
    logic [bdel_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [bdel_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    debounce_scoreboard sb = new();

    bit no_idle;
    bit btn_one;
    bit btn_two;
    int requests_sent;
    int results_seen;
    int idle_cycles;

    button_debounce_edge_latch #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_raw_one    (s_raw_one),
        .s_raw_two    (s_raw_two),
        .s_slot_index (s_slot_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_press_seen (m_press_seen),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Handshakes are sampled at the edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_press_seen);
                results_seen = results_seen + 1;
            end
            if (s_valid && s_ready)
                sb.note_request(bdel_pkg::kind_t'(s_kind), s_raw_one, s_raw_two,
                                s_slot_index);
        end
    end

    initial begin
        int stall;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            stall = no_idle ? 0 : pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("** button_debounce_edge_latch: FAILED **");
        $finish;
    end

    task automatic send_request(bdel_pkg::kind_t kind, bit one, bit two,
                                logic [bdel_pkg::IDX_W-1:0] idx);
        int gap;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_raw_one    <= one;
        s_raw_two    <= two;
        s_slot_index <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        requests_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Holds the sender back until every request has had its result.
    task automatic wait_drain();
        if (results_seen < requests_sent) begin
            s_valid <= 1'b0;
            while (results_seen < requests_sent)
                @(posedge aclk);
        end
    endtask

    task automatic write_reg(bdel_pkg::cfg_idx_t idx,
                             logic [bdel_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    // Bits above a register's width are filled at random; the block must drop them.
    task automatic write_config(logic [bdel_pkg::HOLD_W-1:0]    deb,
                                logic [bdel_pkg::PRE_W-1:0]     pre,
                                logic [bdel_pkg::SLOTCFG_W-1:0] first,
                                logic [bdel_pkg::SLOTCFG_W-1:0] second);
        logic [bdel_pkg::CFG_DATA_W-1:0] data;
        data = bdel_pkg::CFG_DATA_W'($urandom);
        data[bdel_pkg::HOLD_W-1:0] = deb;
        write_reg(bdel_pkg::CFG_DEBOUNCE, data);
        write_reg(bdel_pkg::CFG_PRESCALE, pre);
        data = bdel_pkg::CFG_DATA_W'($urandom);
        data[bdel_pkg::SLOTCFG_W-1:0] = first;
        write_reg(bdel_pkg::CFG_FIRST, data);
        data = bdel_pkg::CFG_DATA_W'($urandom);
        data[bdel_pkg::SLOTCFG_W-1:0] = second;
        write_reg(bdel_pkg::CFG_SECOND, data);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_request();
        int                         r;
        int                         pick;
        bdel_pkg::kind_t            kind;
        bit                         one;
        bit                         two;
        logic [bdel_pkg::IDX_W-1:0] idx;
        r    = $urandom_range(0, 99);
        one  = 1'($urandom_range(0, 1));
        two  = 1'($urandom_range(0, 1));
        idx  = bdel_pkg::IDX_W'($urandom);
        if (r < 60) begin
            kind = bdel_pkg::KIND_TICK;
            // Mostly buttons that hold their level for a while and then change.
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 99) < 35)
                    btn_one = ~btn_one;
                if ($urandom_range(0, 99) < 35)
                    btn_two = ~btn_two;
                one = btn_one;
                two = btn_two;
            end
        end else if (r < 93) begin
            kind = bdel_pkg::KIND_READ;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                idx = bdel_pkg::IDX_W'(sb.first_slot);
            else if (pick < 7)
                idx = bdel_pkg::IDX_W'(sb.second_slot);
            else if (pick < 9)
                idx = bdel_pkg::IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        end else if (r < 96) begin
            kind = bdel_pkg::KIND_RESET;
        end else begin
            kind = bdel_pkg::KIND_CLEAR;
        end
        send_request(kind, one, two, idx);
    endtask

    initial begin
        logic [bdel_pkg::SLOTCFG_W-1:0] slot_a;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_kind        <= bdel_pkg::KIND_TICK;
        s_raw_one     <= 1'b0;
        s_raw_two     <= 1'b0;
        s_slot_index  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= bdel_pkg::CFG_DEBOUNCE;
        cfg_wdata     <= '0;
        no_idle       = 1'b0;
        btn_one       = 1'b0;
        btn_two       = 1'b0;
        requests_sent = 0;
        results_seen  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: the hold-off is still running, so presses are not latched.
        send_request(bdel_pkg::KIND_TICK, 1'b1, 1'b1, 8'd0);
        send_request(bdel_pkg::KIND_TICK, 1'b0, 1'b0, 8'd255);
        send_request(bdel_pkg::KIND_READ, 1'b1, 1'b0, 8'd0);
        send_request(bdel_pkg::KIND_READ, 1'b0, 1'b1, 8'd15);
        send_request(bdel_pkg::KIND_READ, 1'b0, 1'b0, 8'd16);
        send_request(bdel_pkg::KIND_READ, 1'b1, 1'b1, 8'd255);
        send_request(bdel_pkg::KIND_CLEAR, 1'b0, 1'b0, 8'd170);
        send_request(bdel_pkg::KIND_RESET, 1'b1, 1'b0, 8'd85);

        // Zero hold-off and zero reload, both buttons on one slot.
        wait_drain();
        write_config(6'd0, 8'd0, 4'd2, 4'd2);
        send_request(bdel_pkg::KIND_RESET, 1'b0, 1'b0, 8'd0);
        send_request(bdel_pkg::KIND_TICK, 1'b1, 1'b0, 8'd0);
        send_request(bdel_pkg::KIND_READ, 1'b0, 1'b0, 8'd2);
        send_request(bdel_pkg::KIND_READ, 1'b0, 1'b0, 8'd2);
        send_request(bdel_pkg::KIND_TICK, 1'b1, 1'b1, 8'd0);
        send_request(bdel_pkg::KIND_TICK, 1'b1, 1'b1, 8'd0);
        send_request(bdel_pkg::KIND_CLEAR, 1'b0, 1'b0, 8'd0);
        send_request(bdel_pkg::KIND_READ, 1'b0, 1'b0, 8'd2);
        send_request(bdel_pkg::KIND_TICK, 1'b0, 1'b1, 8'd0);
        send_request(bdel_pkg::KIND_TICK, 1'b0, 1'b0, 8'd0);
        send_request(bdel_pkg::KIND_TICK, 1'b1, 1'b1, 8'd0);
        send_request(bdel_pkg::KIND_READ, 1'b1, 1'b1, 8'd2);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drain();
            case (phase)
                0: write_config(6'd0, 8'd0, 4'd0, 4'd15);
                1: write_config(6'd63, 8'd255, 4'd15, 4'd0);
                2: write_config(6'd63, 8'd0, 4'd5, 4'd5);
                3: write_config(6'd0, 8'd255, 4'd15, 4'd15);
                default: begin
                    slot_a = bdel_pkg::SLOTCFG_W'($urandom);
                    write_config(bdel_pkg::HOLD_W'($urandom_range(0, 6)),
                                 bdel_pkg::PRE_W'($urandom_range(0, 3)),
                                 slot_a,
                                 ($urandom_range(0, 3) == 0) ? slot_a
                                                             : bdel_pkg::SLOTCFG_W'($urandom));
                end
            endcase
            no_idle = (phase % 5 == 1);
            if ($urandom_range(0, 1) != 0)
                send_request(bdel_pkg::KIND_RESET, 1'b0, 1'b0,
                             bdel_pkg::IDX_W'($urandom));
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 199) == 0)
                    wait_drain();
                send_random_request();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** button_debounce_edge_latch: PASSED **");
        else
            $display("** button_debounce_edge_latch: FAILED **");
        $finish;
    end

endmodule
